// ----- hdl/wsd_pkg.sv -----
// WebSocket frame deframer: shared types and constants.
// No dependencies.
`default_nettype none
package wsd_pkg;

	localparam int LenW = 32;

	localparam logic [3:0] OpText   = 4'h1;
	localparam logic [3:0] OpBinary = 4'h2;
	localparam logic [3:0] OpClose  = 4'h8;
	localparam logic [3:0] OpPing   = 4'h9;
	localparam logic [3:0] OpPong   = 4'hA;

	localparam logic [6:0] Len16Code = 7'd126;
	localparam logic [6:0] Len64Code = 7'd127;

	localparam logic [3:0] Ext16Bytes = 4'd2;
	localparam logic [3:0] Ext64Bytes = 4'd8;

	typedef enum logic [2:0] {
		KIND_TEXT   = 3'd0,
		KIND_BINARY = 3'd1,
		KIND_CLOSE  = 3'd2,
		KIND_PING   = 3'd3,
		KIND_PONG   = 3'd4,
		KIND_OTHER  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_MASK,
		PH_DATA,
		PH_CLOSED
	} phase_t;

	typedef struct packed {
		logic [LenW-1:0] frame_length;
		logic            close_code_valid;
		logic [15:0]     close_code;
		kind_t           frame_kind;
		logic [3:0]      frame_opcode;
		logic            fin_flag;
		logic            frame_end;
		logic            has_data;
		logic [7:0]      data_byte;
	} result_t;

	function automatic kind_t kind_of(input logic [3:0] op);
		kind_t k;
		unique case (op)
			OpText:   k = KIND_TEXT;
			OpBinary: k = KIND_BINARY;
			OpClose:  k = KIND_CLOSE;
			OpPing:   k = KIND_PING;
			OpPong:   k = KIND_PONG;
			default:  k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/websocket_frame_deframer.sv -----
// WebSocket frame deframer top level: input register, parser, result register.
// Depends on wsd_pkg, wsd_in_stage, wsd_parser, wsd_out_stage.
//
//  port group | dir | contents
//  s_axis     | in  | tdata[7:0] rx_byte
//  m_axis     | out | tdata data_byte, fin, opcode, kind, close code, length;
//             |     | tuser has_data; tlast frame_end
//
// One byte per clock sustained while the master side does not stall; a byte enters the
// input register at its transfer edge and its result, if any, goes on to the result register.
// Reset clears the parse state to expect a new frame header.
// A stalled master side holds the result; one more byte waits in the input
// register, then s_axis_tready drops.
`default_nettype none
module websocket_frame_deframer import wsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] data_byte, [8] fin_flag, [12:9] frame_opcode, [15:13] frame_kind,
	// [31:16] close_code, [32] close_code_valid, [64:33] frame_length, rest 0
	output logic [71:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // [0] has_data
	output logic             m_axis_tlast
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;
	result_t    out_q;

	wsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (valid_s1 && advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_q     (out_q)
	);

	assign m_axis_tdata = {7'b0, out_q.frame_length, out_q.close_code_valid,
		out_q.close_code, out_q.frame_kind, out_q.frame_opcode, out_q.fin_flag,
		out_q.data_byte};
	assign m_axis_tuser = out_q.has_data;
	assign m_axis_tlast = out_q.frame_end;

endmodule
`default_nettype wire

// ----- hdl/wsd_in_stage.sv -----
// WebSocket frame deframer: input register for received bytes.
// Depends on nothing but the stream handshake.
`default_nettype none
module wsd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/wsd_parser.sv -----
// WebSocket frame deframer: header parse, unmasking and frame state.
// Depends on wsd_pkg.
`default_nettype none
module wsd_parser import wsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] byte_s1,
	output logic            res_valid,
	output result_t         res
);

	phase_t          phase_q, phase_d;
	logic            fin_q, fin_d;
	logic [3:0]      op_q, op_d;
	logic            masked_q, masked_d;
	logic [LenW-1:0] len_q, len_d;
	logic [LenW-1:0] rem_q, rem_d;
	logic [3:0]      ext_q, ext_d;
	logic [31:0]     key_q, key_d;
	logic [1:0]      midx_q, midx_d;
	logic [15:0]     cc_q, cc_d;
	logic [1:0]      cbs_q, cbs_d;

	logic            pay_start;
	logic            zero_end;
	logic [7:0]      key_byte;
	logic [7:0]      plain;

	always_comb begin
		unique case (midx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		plain = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		op_d      = op_q;
		masked_d  = masked_q;
		len_d     = len_q;
		rem_d     = rem_q;
		ext_d     = ext_q;
		key_d     = key_q;
		midx_d    = midx_q;
		cc_d      = cc_q;
		cbs_d     = cbs_q;
		pay_start = 1'b0;
		zero_end  = 1'b0;
		if (fire) begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_d   = byte_s1[7];
					op_d    = byte_s1[3:0];
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = byte_s1[7];
					len_d    = '0;
					if (byte_s1[6:0] == Len16Code) begin
						ext_d   = Ext16Bytes;
						phase_d = PH_EXT;
					end else if (byte_s1[6:0] == Len64Code) begin
						ext_d   = Ext64Bytes;
						phase_d = PH_EXT;
					end else begin
						len_d = LenW'(byte_s1[6:0]);
						if (byte_s1[7]) begin
							midx_d  = '0;
							key_d   = '0;
							phase_d = PH_MASK;
						end else begin
							pay_start = 1'b1;
						end
					end
				end
				PH_EXT: begin
					len_d = {len_q[LenW-9:0], byte_s1};
					ext_d = ext_q - 4'd1;
					if (ext_q == 4'd1) begin
						if (masked_q) begin
							midx_d  = '0;
							key_d   = '0;
							phase_d = PH_MASK;
						end else begin
							pay_start = 1'b1;
						end
					end
				end
				PH_MASK: begin
					key_d  = {key_q[23:0], byte_s1};
					midx_d = midx_q + 2'd1;
					if (midx_q == 2'd3) begin
						pay_start = 1'b1;
					end
				end
				PH_DATA: begin
					midx_d = midx_q + 2'd1;
					if (op_q == OpClose && cbs_q < 2'd2) begin
						cc_d  = {cc_q[7:0], plain};
						cbs_d = cbs_q + 2'd1;
					end
					rem_d = rem_q - LenW'(1);
					if (rem_q == LenW'(1)) begin
						phase_d = (op_q == OpClose) ? PH_CLOSED : PH_HDR0;
					end
				end
				PH_CLOSED: begin
					phase_d = PH_CLOSED;
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
			if (pay_start) begin
				rem_d  = len_d;
				midx_d = '0;
				cc_d   = '0;
				cbs_d  = '0;
				if (len_d == '0) begin
					zero_end = 1'b1;
					phase_d  = (op_d == OpClose) ? PH_CLOSED : PH_HDR0;
				end else begin
					phase_d = PH_DATA;
				end
			end
		end
	end

	// result
	always_comb begin
		logic is_data;
		logic end_flag;
		logic cc_ok;
		is_data   = fire && phase_q == PH_DATA;
		end_flag  = zero_end || (is_data && rem_q == LenW'(1));
		cc_ok     = end_flag && op_d == OpClose && cbs_d == 2'd2;
		res_valid = is_data || zero_end;
		res.data_byte        = is_data ? plain : 8'h00;
		res.has_data         = is_data;
		res.frame_end        = end_flag;
		res.fin_flag         = fin_d;
		res.frame_opcode     = op_d;
		res.frame_kind       = kind_of(op_d);
		res.close_code       = cc_ok ? cc_d : 16'h0000;
		res.close_code_valid = cc_ok;
		res.frame_length     = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			rem_q    <= '0;
			ext_q    <= '0;
			key_q    <= '0;
			midx_q   <= '0;
			cc_q     <= '0;
			cbs_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			op_q     <= op_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
			ext_q    <= ext_d;
			key_q    <= key_d;
			midx_q   <= midx_d;
			cc_q     <= cc_d;
			cbs_q    <= cbs_d;
		end
	end

`ifndef SYNTHESIS
	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("closed phase left");
	a_data_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("payload phase with zero count");
	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXT |-> ext_q != 4'd0)
		else $error("extended length phase with zero count");
	a_cc_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.close_code_valid |-> res.frame_end && res.has_data)
		else $error("close code without frame end");
	a_close_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_end && op_d == OpClose |=> phase_q == PH_CLOSED)
		else $error("close frame did not close");
`endif

endmodule
`default_nettype wire

// ----- hdl/wsd_out_stage.sv -----
// WebSocket frame deframer: result register toward the master side.
// Depends on wsd_pkg.
`default_nettype none
module wsd_out_stage import wsd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res,
	output logic         advance,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_q
);

	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer: streams WebSocket frames into s_axis and
// checks every m_axis transfer against a frame parser model kept here.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module testbench;
	import wsd_pkg::*;

	typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;
	typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

	localparam int RandomBytes = 780;
	localparam int CycleLimit = 500000;
	localparam int DrainCycles = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	logic [7:0] rx_stream[$];
	result_t frame_results[$];
	int total_bytes = 0;
	int sent_bytes = 0;
	int mismatches = 0;
	int cycles = 0;
	int tx_idle_pct;
	int rx_stall_pct;

	// parser state
	phase_t ph = PH_HDR0;
	logic fin_r = 1'b0;
	logic [3:0] op_r = 4'h0;
	logic masked_r = 1'b0;
	logic [LenW-1:0] len_acc = '0;
	logic [LenW-1:0] remaining = '0;
	logic [3:0] ext_left = 4'h0;
	logic [31:0] key = 32'h0;
	logic [1:0] key_idx = 2'd0;
	logic [15:0] code_r = 16'h0;
	logic [1:0] code_cnt = 2'd0;
	logic closed = 1'b0;

	websocket_frame_deframer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	always_comb begin
		case ((total_bytes == 0) ? 0 : (sent_bytes * 4) / total_bytes)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct = 62;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 62;
			end
			default: begin
				tx_idle_pct = 7;
				rx_stall_pct = 7;
			end
		endcase
	end

	task push_result(input logic [7:0] d, input logic has, input logic last);
		result_t r;
		logic code_ok;
		code_ok = last && (op_r == OpClose) && (code_cnt >= 2'd2);
		r.data_byte = d;
		r.has_data = has;
		r.frame_end = last;
		r.fin_flag = fin_r;
		r.frame_opcode = op_r;
		case (op_r)
			OpText:   r.frame_kind = KIND_TEXT;
			OpBinary: r.frame_kind = KIND_BINARY;
			OpClose:  r.frame_kind = KIND_CLOSE;
			OpPing:   r.frame_kind = KIND_PING;
			OpPong:   r.frame_kind = KIND_PONG;
			default:  r.frame_kind = KIND_OTHER;
		endcase
		r.close_code = code_ok ? code_r : 16'h0;
		r.close_code_valid = code_ok;
		r.frame_length = len_acc;
		frame_results.push_back(r);
	endtask

	task end_frame;
		if (op_r == OpClose) begin
			closed = 1'b1;
			ph = PH_CLOSED;
		end else begin
			ph = PH_HDR0;
		end
	endtask

	task start_payload;
		remaining = len_acc;
		key_idx = 2'd0;
		code_r = 16'h0;
		code_cnt = 2'd0;
		if (remaining == '0) begin
			push_result(8'h00, 1'b0, 1'b1);
			end_frame();
		end else begin
			ph = PH_DATA;
		end
	endtask

	task length_done;
		if (masked_r) begin
			key_idx = 2'd0;
			key = 32'h0;
			ph = PH_MASK;
		end else begin
			start_payload();
		end
	endtask

	task parse_byte(input logic [7:0] rx);
		logic [7:0] d;
		if (closed) begin
			ph = PH_CLOSED;
			return;
		end
		case (ph)
			PH_HDR0: begin
				fin_r = rx[7];
				op_r = rx[3:0];
				ph = PH_HDR1;
			end
			PH_HDR1: begin
				masked_r = rx[7];
				len_acc = '0;
				if (rx[6:0] == Len16Code) begin
					ext_left = Ext16Bytes;
					ph = PH_EXT;
				end else if (rx[6:0] == Len64Code) begin
					ext_left = Ext64Bytes;
					ph = PH_EXT;
				end else begin
					len_acc = LenW'(rx[6:0]);
					length_done();
				end
			end
			PH_EXT: begin
				len_acc = {len_acc[LenW-9:0], rx};
				ext_left = ext_left - 4'd1;
				if (ext_left == 4'd0)
					length_done();
			end
			PH_MASK: begin
				key = {key[23:0], rx};
				key_idx = key_idx + 2'd1;
				if (key_idx == 2'd0)
					start_payload();
			end
			PH_DATA: begin
				d = rx ^ (masked_r ? 8'(key >> (8 * (3 - key_idx))) : 8'h00);
				key_idx = key_idx + 2'd1;
				if (op_r == OpClose && code_cnt < 2'd2) begin
					code_r = {code_r[7:0], d};
					code_cnt = code_cnt + 2'd1;
				end
				remaining = remaining - 1'b1;
				push_result(d, 1'b1, remaining == '0);
				if (remaining == '0)
					end_frame();
			end
			default: ph = PH_HDR0;
		endcase
	endtask

	task add_frame(input logic [7:0] hdr0, input logic mask_on, input len_enc_t enc,
			input logic [31:0] len, input logic [31:0] len_hi, input fill_t fill);
		logic [31:0] mkey;
		rx_stream.push_back(hdr0);
		case (enc)
			ENC_SHORT: rx_stream.push_back({mask_on, len[6:0]});
			ENC_EXT16: begin
				rx_stream.push_back({mask_on, Len16Code});
				rx_stream.push_back(len[15:8]);
				rx_stream.push_back(len[7:0]);
			end
			default: begin
				rx_stream.push_back({mask_on, Len64Code});
				for (int i = 3; i >= 0; i--)
					rx_stream.push_back(len_hi[8*i +: 8]);
				for (int i = 3; i >= 0; i--)
					rx_stream.push_back(len[8*i +: 8]);
			end
		endcase
		if (mask_on) begin
			mkey = $urandom;
			for (int i = 3; i >= 0; i--)
				rx_stream.push_back(mkey[8*i +: 8]);
		end
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZEROS: rx_stream.push_back(8'h00);
				FILL_ONES:  rx_stream.push_back(8'hFF);
				default:    rx_stream.push_back(8'($urandom));
			endcase
		end
	endtask

	task compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata);
				sent_bytes <= sent_bytes + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= rx_stream.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_results.size() == 0) begin
					$error("unexpected result transfer: tdata %0h", m_axis_tdata);
					mismatches++;
				end else begin
					result_t want;
					want = frame_results.pop_front();
					compare_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
					compare_field("has_data", want.has_data, m_axis_tuser);
					compare_field("frame_end", want.frame_end, m_axis_tlast);
					compare_field("fin_flag", want.fin_flag, m_axis_tdata[8]);
					compare_field("frame_opcode", want.frame_opcode, m_axis_tdata[12:9]);
					compare_field("frame_kind", want.frame_kind, m_axis_tdata[15:13]);
					compare_field("close_code", want.close_code, m_axis_tdata[31:16]);
					compare_field("close_code_valid", want.close_code_valid,
						m_axis_tdata[32]);
					compare_field("frame_length", want.frame_length, m_axis_tdata[64:33]);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int base;
		logic [3:0] op;
		logic [31:0] len;
		logic [31:0] len_hi;
		len_enc_t enc;
		fill_t fill;
		int pick;

		// directed frames
		add_frame({1'b1, 3'b000, OpText}, 1'b0, ENC_SHORT, 0, 0, FILL_RANDOM);
		add_frame({1'b0, 3'b000, OpBinary}, 1'b1, ENC_SHORT, 4, 0, FILL_ONES);
		add_frame({1'b1, 3'b000, OpPing}, 1'b1, ENC_SHORT, 1, 0, FILL_ZEROS);
		add_frame({1'b1, 3'b000, OpPong}, 1'b0, ENC_SHORT, 3, 0, FILL_RANDOM);
		add_frame(8'h00, 1'b0, ENC_SHORT, 2, 0, FILL_ONES);
		add_frame(8'hFF, 1'b1, ENC_SHORT, 5, 0, FILL_RANDOM);
		add_frame(8'h73, 1'b0, ENC_SHORT, 125, 0, FILL_RANDOM);
		add_frame({1'b1, 3'b000, OpBinary}, 1'b1, ENC_EXT16, 6, 0, FILL_RANDOM);
		add_frame({1'b1, 3'b000, OpText}, 1'b0, ENC_EXT16, 0, 0, FILL_RANDOM);
		add_frame({1'b1, 3'b000, OpBinary}, 1'b0, ENC_EXT64, 0, 32'hFFFF_FFFF,
			FILL_RANDOM);
		add_frame({1'b0, 3'b111, OpBinary}, 1'b1, ENC_EXT64, 3, 32'h8000_0001,
			FILL_RANDOM);

		// random frames, close opcode kept for the end
		base = rx_stream.size();
		while (rx_stream.size() < base + RandomBytes) begin
			pick = $urandom_range(9);
			case (pick)
				0, 1:    op = OpText;
				2, 3:    op = OpBinary;
				4:       op = OpPing;
				5:       op = OpPong;
				6:       op = 4'h0;
				default: op = 4'($urandom);
			endcase
			if (op == OpClose)
				op = OpBinary;
			pick = $urandom_range(19);
			len_hi = 32'h0;
			if (pick < 16) begin
				enc = ENC_SHORT;
				len = ($urandom_range(19) == 0) ? $urandom_range(13, 125) : $urandom_range(12);
			end else if (pick < 18) begin
				enc = ENC_EXT16;
				len = $urandom_range(40);
			end else begin
				enc = ENC_EXT64;
				len = $urandom_range(20);
				if ($urandom_range(1))
					len_hi = $urandom;
			end
			pick = $urandom_range(9);
			fill = (pick == 0) ? FILL_ZEROS : (pick == 1) ? FILL_ONES : FILL_RANDOM;
			add_frame({1'($urandom), 3'($urandom), op}, 1'($urandom), enc, len, len_hi, fill);
		end

		// closing frame, then bytes that must be dropped
		pick = $urandom_range(3);
		len = (pick == 3) ? $urandom_range(3, 9) : pick;
		add_frame({1'($urandom), 3'($urandom), OpClose}, 1'($urandom), ENC_SHORT, len, 0,
			FILL_RANDOM);
		repeat ($urandom_range(4, 16))
			rx_stream.push_back(8'($urandom));
		total_bytes = rx_stream.size();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (sent_bytes < total_bytes || frame_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0 && frame_results.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/wsd_pkg.sv
hdl/wsd_in_stage.sv
hdl/wsd_parser.sv
hdl/wsd_out_stage.sv
hdl/websocket_frame_deframer.sv
bench/testbench.sv
